// ===== rtl/msep_pkg.sv =====
// Shared types for the score event parser: result kinds and the queue entry
// passed from the byte parser to the result sequencer. No dependencies.
package msep_pkg;

    typedef enum logic [2:0] {
        KIND_NOTE_OFF = 3'd0,
        KIND_NOTE_ON  = 3'd1,
        KIND_BEND     = 3'd2,
        KIND_CHAN_VOL = 3'd3,
        KIND_DELAY    = 3'd4,
        KIND_END_STOP = 3'd5,
        KIND_LOOP     = 3'd6,
        KIND_TRUNC    = 3'd7
    } t_kind;

    localparam logic [2:0] TYPE_RELEASE = 3'd0;
    localparam logic [2:0] TYPE_PLAY    = 3'd1;
    localparam logic [2:0] TYPE_BEND    = 3'd2;
    localparam logic [2:0] TYPE_CTRL    = 3'd4;
    localparam logic [2:0] TYPE_MEASURE = 3'd5;
    localparam logic [2:0] TYPE_END     = 3'd6;

    localparam logic [6:0] CTRL_VOLUME  = 7'd3;
    localparam logic [6:0] LEVEL_RESET  = 7'd100;

    typedef struct packed {
        logic        has_main;
        logic        trunc;
        t_kind       kind;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [7:0]  value;
        logic [6:0]  level;
        logic [31:0] delay;
    } t_entry;

endpackage

// ===== rtl/msep_front.sv =====
// Byte parser: decodes score bytes one per accepted cycle, keeps channel
// tables, and pushes one queue entry per byte with results. Uses msep_pkg.
module msep_front #(
    parameter int CHANNELS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_accept,
    input  logic            i_cmd,
    input  logic [7:0]      i_data_byte,
    input  logic            i_final_req,
    output logic            o_push,
    output msep_pkg::t_entry o_entry
);

    localparam int CH_W = $clog2(CHANNELS);

    typedef enum logic [2:0] {
        PH_DESC  = 3'd0,
        PH_ARG   = 3'd1,
        PH_VOL   = 3'd2,
        PH_CNUM  = 3'd3,
        PH_CVAL  = 3'd4,
        PH_DELAY = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_desc, n_desc;
    logic [6:0]  r_pend, n_pend;
    logic [31:0] r_accum, n_accum;
    logic        r_running, n_running;
    logic        r_loop;
    logic [6:0]  r_vel [CHANNELS];
    logic [6:0]  r_lvl [CHANNELS];

    logic            rewind;
    logic            vel_we;
    logic            lvl_we;
    logic            ended;
    logic [2:0]      cur_type;
    logic [3:0]      cur_ch;
    logic [CH_W-1:0] tab_idx;
    logic [2:0]      b_type;
    msep_pkg::t_entry e;

    assign cur_type = r_desc[6:4];
    assign cur_ch   = r_desc[3:0];
    assign tab_idx  = cur_ch[CH_W-1:0];
    assign b_type   = i_data_byte[6:4];

    always_comb begin
        n_phase   = r_phase;
        n_desc    = r_desc;
        n_pend    = r_pend;
        n_accum   = r_accum;
        n_running = r_running;
        rewind    = 1'b0;
        vel_we    = 1'b0;
        lvl_we    = 1'b0;
        ended     = 1'b0;
        e         = '0;
        e.kind    = msep_pkg::KIND_NOTE_OFF;
        if (i_accept) begin
            if (i_cmd) begin
                rewind    = 1'b1;
                n_running = 1'b1;
                n_phase   = PH_DESC;
                n_accum   = '0;
            end else if (r_running) begin
                unique case (r_phase)
                    PH_ARG: begin
                        n_phase = r_desc[7] ? PH_DELAY : PH_DESC;
                        n_accum = '0;
                        if (cur_type == msep_pkg::TYPE_RELEASE) begin
                            e.has_main = 1'b1;
                            e.kind     = msep_pkg::KIND_NOTE_OFF;
                            e.channel  = cur_ch;
                            e.note     = i_data_byte[6:0];
                        end else if (cur_type == msep_pkg::TYPE_PLAY) begin
                            if (i_data_byte[7]) begin
                                n_pend  = i_data_byte[6:0];
                                n_phase = PH_VOL;
                                n_accum = r_accum;
                            end else begin
                                e.has_main = 1'b1;
                                e.kind     = msep_pkg::KIND_NOTE_ON;
                                e.channel  = cur_ch;
                                e.note     = i_data_byte[6:0];
                                e.value    = {1'b0, r_vel[tab_idx]};
                                e.level    = r_lvl[tab_idx];
                            end
                        end else if (cur_type == msep_pkg::TYPE_BEND) begin
                            e.has_main = 1'b1;
                            e.kind     = msep_pkg::KIND_BEND;
                            e.channel  = cur_ch;
                            e.value    = i_data_byte;
                        end
                    end
                    PH_VOL: begin
                        vel_we     = 1'b1;
                        e.has_main = 1'b1;
                        e.kind     = msep_pkg::KIND_NOTE_ON;
                        e.channel  = cur_ch;
                        e.note     = r_pend;
                        e.value    = {1'b0, i_data_byte[6:0]};
                        e.level    = r_lvl[tab_idx];
                        n_phase    = r_desc[7] ? PH_DELAY : PH_DESC;
                        n_accum    = '0;
                    end
                    PH_CNUM: begin
                        n_pend  = i_data_byte[6:0];
                        n_phase = PH_CVAL;
                    end
                    PH_CVAL: begin
                        if (r_pend == msep_pkg::CTRL_VOLUME) begin
                            lvl_we     = 1'b1;
                            e.has_main = 1'b1;
                            e.kind     = msep_pkg::KIND_CHAN_VOL;
                            e.channel  = cur_ch;
                            e.value    = {1'b0, i_data_byte[6:0]};
                        end
                        n_phase = r_desc[7] ? PH_DELAY : PH_DESC;
                        n_accum = '0;
                    end
                    PH_DELAY: begin
                        n_accum = {r_accum[24:0], i_data_byte[6:0]};
                        if (!i_data_byte[7]) begin
                            e.has_main = 1'b1;
                            e.kind     = msep_pkg::KIND_DELAY;
                            e.channel  = cur_ch;
                            e.delay    = {r_accum[24:0], i_data_byte[6:0]};
                            n_accum    = '0;
                            n_phase    = PH_DESC;
                        end
                    end
                    default: begin
                        n_desc = i_data_byte;
                        if (b_type == msep_pkg::TYPE_END) begin
                            ended      = 1'b1;
                            e.has_main = 1'b1;
                            e.channel  = i_data_byte[3:0];
                            n_phase    = PH_DESC;
                            if (r_loop) begin
                                rewind  = 1'b1;
                                n_accum = '0;
                                e.kind  = msep_pkg::KIND_LOOP;
                            end else begin
                                n_running = 1'b0;
                                e.kind    = msep_pkg::KIND_END_STOP;
                            end
                        end else if (b_type == msep_pkg::TYPE_MEASURE) begin
                            n_phase = i_data_byte[7] ? PH_DELAY : PH_DESC;
                            n_accum = '0;
                        end else if (b_type == msep_pkg::TYPE_CTRL) begin
                            n_phase = PH_CNUM;
                        end else begin
                            n_phase = PH_ARG;
                        end
                    end
                endcase
                if (i_final_req && !ended) begin
                    n_running = 1'b0;
                    n_phase   = PH_DESC;
                    n_accum   = '0;
                    e.trunc   = 1'b1;
                end
            end
        end
    end

    assign o_push  = e.has_main || e.trunc;
    assign o_entry = e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DESC;
            r_desc    <= '0;
            r_pend    <= '0;
            r_accum   <= '0;
            r_running <= 1'b0;
            r_loop    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_vel[i] <= msep_pkg::LEVEL_RESET;
                r_lvl[i] <= msep_pkg::LEVEL_RESET;
            end
        end else begin
            r_phase   <= n_phase;
            r_desc    <= n_desc;
            r_pend    <= n_pend;
            r_accum   <= n_accum;
            r_running <= n_running;
            if (i_cfg_wr_en) begin
                r_loop <= i_cfg_wr_data;
            end
            if (rewind) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_vel[i] <= msep_pkg::LEVEL_RESET;
                    r_lvl[i] <= msep_pkg::LEVEL_RESET;
                end
            end else begin
                if (vel_we) begin
                    r_vel[tab_idx] <= i_data_byte[6:0];
                end
                if (lvl_we) begin
                    r_lvl[tab_idx] <= i_data_byte[6:0];
                end
            end
        end
    end

endmodule

// ===== rtl/msep_queue.sv =====
// Small FIFO of parsed entries between the parser and the sequencer.
// Uses msep_pkg for the entry type.
module msep_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  msep_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_avail,
    output msep_pkg::t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    msep_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/msep_back.sv =====
// Result sequencer: expands each queue entry into one or two results and
// holds them in the output register under stall. Uses msep_pkg.
module msep_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  msep_pkg::t_entry i_head,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [2:0]       o_kind,
    output logic [3:0]       o_channel,
    output logic [6:0]       o_note,
    output logic [7:0]       o_value,
    output logic [6:0]       o_chan_level,
    output logic [31:0]      o_delay_ticks,
    output logic             o_last_of_run
);

    logic        r_valid;
    logic        r_main_done;
    logic [2:0]  r_kind;
    logic [3:0]  r_channel;
    logic [6:0]  r_note;
    logic [7:0]  r_value;
    logic [6:0]  r_level;
    logic [31:0] r_delay;
    logic        r_last;

    logic load;
    logic send_main;

    assign load      = !r_valid || !i_out_stall;
    assign send_main = i_head.has_main && !r_main_done;
    assign o_pop     = load && i_avail && !(send_main && i_head.trunc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_main_done <= 1'b0;
        end else if (load) begin
            r_valid <= i_avail;
            if (i_avail) begin
                r_main_done <= send_main && i_head.trunc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_avail) begin
            if (send_main) begin
                r_kind    <= i_head.kind;
                r_channel <= i_head.channel;
                r_note    <= i_head.note;
                r_value   <= i_head.value;
                r_level   <= i_head.level;
                r_delay   <= i_head.delay;
                r_last    <= !i_head.trunc;
            end else begin
                r_kind    <= msep_pkg::KIND_TRUNC;
                r_channel <= '0;
                r_note    <= '0;
                r_value   <= '0;
                r_level   <= '0;
                r_delay   <= '0;
                r_last    <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_channel     = r_channel;
    assign o_note        = r_note;
    assign o_value       = r_value;
    assign o_chan_level  = r_level;
    assign o_delay_ticks = r_delay;
    assign o_last_of_run = r_last;

endmodule

// ===== rtl/mus_score_event_parser.sv =====
// Top level of the score event parser: byte parser, entry queue, result
// sequencer. Depends on msep_pkg, msep_front, msep_queue, msep_back.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_cmd, i_data_byte, i_final_req
//   out      source     o_out_valid / i_out_stall  o_kind .. o_last_of_run
//   cfg      sink       i_cfg_wr_en                i_cfg_wr_data (loop_song)
//
// One score byte is taken per cycle unless the input stalls; the parser updates
// its state in that cycle. A result goes through the queue into the output
// register; a byte with two results holds the sequencer until both are loaded.
// Input stalls only while the QUEUE_DEPTH-entry queue is full.
// Reset: stopped, descriptor phase, all channel levels and velocities 100, loop off.
module mus_score_event_parser #(
    parameter int CHANNELS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_channel,
    output logic [6:0]  o_note,
    output logic [7:0]  o_value,
    output logic [6:0]  o_chan_level,
    output logic [31:0] o_delay_ticks,
    output logic        o_last_of_run
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    logic             avail;
    msep_pkg::t_entry entry;
    msep_pkg::t_entry head;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    msep_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_data_byte   (i_data_byte),
        .i_final_req   (i_final_req),
        .o_push        (push),
        .o_entry       (entry)
    );

    msep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_head  (head)
    );

    msep_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (avail),
        .i_head        (head),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_channel     (o_channel),
        .o_note        (o_note),
        .o_value       (o_value),
        .o_chan_level  (o_chan_level),
        .o_delay_ticks (o_delay_ticks),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/msep_checker.sv =====
// Port-level checks for mus_score_event_parser, attached by bind.
// Depends on msep_pkg and the top level's ports.
module msep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [6:0]  o_note,
    input logic [6:0]  o_chan_level,
    input logic [31:0] o_delay_ticks,
    input logic        o_last_of_run
);

    // stop, restart and truncation results always close their transaction
    a_stop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == msep_pkg::KIND_END_STOP ||
                        o_kind == msep_pkg::KIND_LOOP ||
                        o_kind == msep_pkg::KIND_TRUNC) |-> o_last_of_run)
        else $error("stop result without last_of_run");

    a_note_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != msep_pkg::KIND_NOTE_OFF &&
        o_kind != msep_pkg::KIND_NOTE_ON |-> o_note == '0 && o_chan_level == '0)
        else $error("note fields set on non-note result");

    a_delay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != msep_pkg::KIND_DELAY |-> o_delay_ticks == '0)
        else $error("delay set on non-delay result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) &&
        $stable(o_last_of_run) && $stable(o_delay_ticks))
        else $error("stalled result changed");

endmodule

bind mus_score_event_parser msep_checker u_msep_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_note        (o_note),
    .o_chan_level  (o_chan_level),
    .o_delay_ticks (o_delay_ticks),
    .o_last_of_run (o_last_of_run)
);
